@@ src/tc_pkg.sv @@
`default_nettype none

package tc_pkg;

    // configuration register indexes
    localparam logic [1:0] CFG_THRESHOLD    = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    // configuration field widths and reset values
    localparam int CFG_W     = 11;
    localparam int THR_W     = 8;
    localparam int CX_W      = 10;
    localparam int CY_W      = 10;
    localparam int HIT_W     = 21;
    localparam logic [THR_W-1:0] THR_RESET = 8'd128;
    localparam logic [CFG_W-1:0] DIM_RESET = 11'd1024;

    // frame-end sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD_X,
        S_WAIT_X,
        S_LOAD_Y,
        S_WAIT_Y,
        S_EMIT
    } tc_state_t;

    // sequencer to divider
    typedef struct packed {
        logic start;
    } div_ctrl_t;

    // divider to sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

@@ src/tc_divider.sv @@
`default_nettype none

module tc_divider
    import tc_pkg::*;
#(
    parameter int DVD_W = 36,
    parameter int DVS_W = 21,
    parameter int Q_W   = 10
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire div_ctrl_t        ctrl,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output div_stat_t             stat,
    output logic      [Q_W-1:0]   quotient
);

    localparam int STEP_W = $clog2(Q_W + 1);

    logic [DVD_W-1:0]  rem_reg;
    logic [DVD_W-1:0]  dsr_reg;
    logic [Q_W-1:0]    quo_reg;
    logic [STEP_W-1:0] step_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DVD_W:0]    diff;
    logic              fits;

    // one restoring step: trial subtract of the shifted divisor
    assign diff = {1'b0, rem_reg} - {1'b0, dsr_reg};
    assign fits = ~diff[DVD_W];

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_W'(Q_W);
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == STEP_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder, divisor and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            rem_reg <= dividend;
            dsr_reg <= DVD_W'(divisor) << (Q_W - 1);
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_reg <= diff[DVD_W-1:0];
            end
            dsr_reg <= dsr_reg >> 1;
            quo_reg <= (quo_reg << 1) | Q_W'(fits);
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

`default_nettype wire

@@ src/threshold_centroid_top.sv @@
`default_nettype none

// channel   direction  handshake             payload
// input     in         in_valid / in_stall   pixel
// output    out        out_valid / out_stall found, center_x, center_y, hit_count
// config    in         cfg_we                cfg_index, cfg_data
//
// pixels are taken one per cycle while in_stall is low; the last pixel of a
// frame is followed by in_stall while one shared divider computes x then y,
// each quotient Q bits wide (Q = bits of the larger max dimension, 10 at defaults).
// reset clears position, sums, count and out_valid; config takes its
// reset values. the result sits in an output register, so a held out_stall
// only blocks input when the next frame end arrives.

module threshold_centroid_top
    import tc_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire logic [7:0]       pixel,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output logic                  found,
    output logic      [CX_W-1:0]  center_x,
    output logic      [CY_W-1:0]  center_y,
    output logic      [HIT_W-1:0] hit_count,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [CFG_W-1:0] cfg_data
);

    localparam int COL_W  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
    localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int Q_W    = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int CNT_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int SUM_W  = CNT_W + Q_W;
    localparam int DW_W   = $clog2(MAX_WIDTH + 1);
    localparam int DH_W   = $clog2(MAX_HEIGHT + 1);
    localparam int DM_W   = (DW_W > DH_W) ? DW_W : DH_W;
    localparam int CMP_W  = ((DM_W > CFG_W) ? DM_W : CFG_W) + 1;

    tc_state_t         state_reg, state_next;
    logic [THR_W-1:0]  thr_reg;
    logic [CFG_W-1:0]  width_reg;
    logic [CFG_W-1:0]  height_reg;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [SUM_W-1:0]  sum_x_reg, sum_x_next;
    logic [SUM_W-1:0]  sum_y_reg, sum_y_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [Q_W-1:0]    cx_reg;
    logic [Q_W-1:0]    cy_reg;
    logic              out_valid_reg;
    logic              found_reg;
    logic [CX_W-1:0]   center_x_reg;
    logic [CY_W-1:0]   center_y_reg;
    logic [HIT_W-1:0]  hit_reg;

    logic              in_acc;
    logic              hit;
    logic [CMP_W-1:0]  w_eff, h_eff;
    logic [CMP_W-1:0]  w_raw, h_raw;
    logic              last_col, last_row, frame_end;
    logic              cap_x, cap_y, emit_load, clear_acc;
    div_ctrl_t         div_ctrl;
    div_stat_t         div_stat;
    logic [SUM_W-1:0]  div_dividend;
    logic [Q_W-1:0]    div_quotient;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= THR_RESET;
            width_reg  <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_THRESHOLD:    thr_reg    <= cfg_data[THR_W-1:0];
                CFG_FRAME_WIDTH:  width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: height_reg <= cfg_data;
                default:          ;
            endcase
        end
    end

    // clamp frame dimensions to 1..max
    always_comb
    begin
        w_raw = CMP_W'(width_reg);
        h_raw = CMP_W'(height_reg);
        if (w_raw == '0)
            w_eff = CMP_W'(1);
        else if (w_raw > CMP_W'(MAX_WIDTH))
            w_eff = CMP_W'(MAX_WIDTH);
        else
            w_eff = w_raw;
        if (h_raw == '0)
            h_eff = CMP_W'(1);
        else if (h_raw > CMP_W'(MAX_HEIGHT))
            h_eff = CMP_W'(MAX_HEIGHT);
        else
            h_eff = h_raw;
    end

    // raster position and accumulation
    assign in_acc    = in_valid && !in_stall;
    assign hit       = pixel > thr_reg;
    assign last_col  = (CMP_W'(col_reg) + CMP_W'(1)) >= w_eff;
    assign last_row  = (CMP_W'(row_reg) + CMP_W'(1)) >= h_eff;
    assign frame_end = in_acc && last_col && last_row;

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        sum_x_next = sum_x_reg;
        sum_y_next = sum_y_reg;
        cnt_next   = cnt_reg;
        if (clear_acc)
        begin
            sum_x_next = '0;
            sum_y_next = '0;
            cnt_next   = '0;
        end
        else if (in_acc)
        begin
            if (hit)
            begin
                sum_x_next = sum_x_reg + SUM_W'(col_reg);
                sum_y_next = sum_y_reg + SUM_W'(row_reg);
                cnt_next   = cnt_reg + CNT_W'(1);
            end
            if (!last_col)
            begin
                col_next = col_reg + COL_W'(1);
            end
            else
            begin
                col_next = '0;
                row_next = last_row ? '0 : row_reg + ROW_W'(1);
            end
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:   if (frame_end) state_next = S_LOAD_X;
            S_LOAD_X: state_next = S_WAIT_X;
            S_WAIT_X: if (div_stat.done) state_next = S_LOAD_Y;
            S_LOAD_Y: state_next = S_WAIT_Y;
            S_WAIT_Y: if (div_stat.done) state_next = S_EMIT;
            S_EMIT:   if (!out_valid_reg || !out_stall) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall       = 1'b1;
        div_ctrl.start = 1'b0;
        div_dividend   = sum_x_reg;
        cap_x          = 1'b0;
        cap_y          = 1'b0;
        emit_load      = 1'b0;
        case (state_reg)
            S_IDLE:   in_stall = 1'b0;
            S_LOAD_X: div_ctrl.start = 1'b1;
            S_WAIT_X: cap_x = div_stat.done;
            S_LOAD_Y:
            begin
                div_ctrl.start = 1'b1;
                div_dividend   = sum_y_reg;
            end
            S_WAIT_Y: cap_y = div_stat.done;
            S_EMIT:   emit_load = !out_valid_reg || !out_stall;
            default:  in_stall = 1'b1;
        endcase
    end

    assign clear_acc = emit_load;

    // shared divider for both centres
    tc_divider #(
        .DVD_W (SUM_W),
        .DVS_W (CNT_W),
        .Q_W   (Q_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (div_ctrl),
        .dividend (div_dividend),
        .divisor  (cnt_reg),
        .stat     (div_stat),
        .quotient (div_quotient)
    );

    // control and accumulator registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            col_reg       <= '0;
            row_reg       <= '0;
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            row_reg   <= row_next;
            sum_x_reg <= sum_x_next;
            sum_y_reg <= sum_y_next;
            cnt_reg   <= cnt_next;
            if (emit_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // quotient capture and output slot
    always_ff @(posedge clk)
    begin
        if (cap_x)
            cx_reg <= div_quotient;
        if (cap_y)
            cy_reg <= div_quotient;
        if (emit_load)
        begin
            found_reg    <= cnt_reg != '0;
            center_x_reg <= (cnt_reg != '0) ? CX_W'(cx_reg) : '0;
            center_y_reg <= (cnt_reg != '0) ? CY_W'(cy_reg) : '0;
            hit_reg      <= HIT_W'(cnt_reg);
        end
    end

    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign center_x  = center_x_reg;
    assign center_y  = center_y_reg;
    assign hit_count = hit_reg;

    // checks on sequencer and divider interplay
    a_start_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_ctrl.start |-> !div_stat.busy)
        else $error("divider started while busy");

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_WAIT_X || state_reg == S_WAIT_Y))
        else $error("divider finished outside a wait state");

    a_no_pixel_while_div: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |-> !div_stat.busy)
        else $error("pixel taken while divider running");

    a_empty_frame_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !found) |-> (center_x == '0 && center_y == '0))
        else $error("empty frame reports nonzero centre");

endmodule

`default_nettype wire
